[rtl/core/tsch_pkg.sv]
// Package for the periodic task timer scheduler.
// Holds command and status codes, fixed field widths and parameter defaults.
// No dependencies.
package tsch_pkg;

    // Parameter defaults
    localparam int TASK_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;
    localparam int TAG_BITS_DEF   = 16;

    // Fixed field widths
    localparam int CMD_BITS    = 2;
    localparam int PERIOD_BITS = 31;
    localparam int STATUS_BITS = 2;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_TICK     = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_COMPLETE = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NOP      = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_FIRE = 2'd2;

    // Control of the earliest-due selection unit
    typedef struct packed {
        logic clear;   // forget the current best before a scan
        logic sample;  // consider the candidate on this cycle
    } pick_ctl_t;

endpackage

[rtl/core/tsch_in_if.sv]
// Input channel of the scheduler: valid/ready handshake and command payload.
// Depends on tsch_pkg.
interface tsch_in_if #(
    parameter int TAG_BITS = tsch_pkg::TAG_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic [tsch_pkg::CMD_BITS-1:0]    command;
    logic [tsch_pkg::PERIOD_BITS-1:0] interval_ticks;
    logic [TAG_BITS-1:0]              task_tag;
    logic                             task_done;

    modport source (
        output valid, command, interval_ticks, task_tag, task_done,
        input  ready
    );
    modport sink (
        input  valid, command, interval_ticks, task_tag, task_done,
        output ready
    );
endinterface

[rtl/core/tsch_out_if.sv]
// Result channel of the scheduler: valid/ready handshake and result payload.
// Depends on tsch_pkg.
interface tsch_out_if #(
    parameter int SLOT_BITS  = $clog2(tsch_pkg::TASK_SLOTS_DEF),
    parameter int COUNT_BITS = $clog2(tsch_pkg::TASK_SLOTS_DEF + 1),
    parameter int TAG_BITS   = tsch_pkg::TAG_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic [tsch_pkg::STATUS_BITS-1:0] status;
    logic                             fire_valid;
    logic [SLOT_BITS-1:0]             fire_slot;
    logic [TAG_BITS-1:0]              fire_tag;
    logic [COUNT_BITS-1:0]            task_count;

    modport source (
        output valid, status, fire_valid, fire_slot, fire_tag, task_count,
        input  ready
    );
    modport sink (
        input  valid, status, fire_valid, fire_slot, fire_tag, task_count,
        output ready
    );
endinterface

[rtl/core/tsch_mem.sv]
// Task table memory: one write port, one read port with registered data.
// No dependencies.
module tsch_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 79
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/core/tsch_pick.sv]
// Earliest-due selection unit: tracks the best due candidate over a slot scan.
// Depends on tsch_pkg (pick_ctl_t).
module tsch_pick #(
    parameter int TASK_SLOTS = tsch_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = tsch_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS   = tsch_pkg::TAG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsch_pkg::pick_ctl_t           ctl,
    input  logic [TIME_BITS-1:0]          now,
    input  logic [$clog2(TASK_SLOTS)-1:0] cand_idx,
    input  logic [TIME_BITS-1:0]          cand_due,
    input  logic [TAG_BITS-1:0]           cand_tag,
    output logic                          have,
    output logic [$clog2(TASK_SLOTS)-1:0] best_idx,
    output logic [TAG_BITS-1:0]           best_tag
);
    localparam int SLOT_BITS = $clog2(TASK_SLOTS);

    logic                 have_reg, have_next;
    logic [SLOT_BITS-1:0] best_idx_reg;
    logic [TIME_BITS-1:0] best_due_reg;
    logic [TAG_BITS-1:0]  best_tag_reg;
    logic [TIME_BITS-1:0] age;
    logic [TIME_BITS-1:0] lead;
    logic                 take;

    // Due when now - due is not negative; earlier when due - best is negative.
    // Strict compare keeps the lower slot on a tie, slots come in ascending.
    always_comb
    begin
        age  = now - cand_due;
        lead = cand_due - best_due_reg;
        take = ctl.sample && !age[TIME_BITS-1] && (!have_reg || lead[TIME_BITS-1]);
        have_next = have_reg;
        if (ctl.clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cand_idx;
            best_due_reg <= cand_due;
            best_tag_reg <= cand_tag;
        end
    end

    assign have     = have_reg;
    assign best_idx = best_idx_reg;
    assign best_tag = best_tag_reg;
endmodule

[rtl/core/periodic_task_timer_scheduler.sv]
// Top level of the periodic task timer scheduler.
// Depends on tsch_pkg, tsch_in_if, tsch_out_if, tsch_mem and tsch_pick.
//
// The block keeps up to TASK_SLOTS periodic tasks, each with a period, a tag
// and a next-due time held in one memory entry; valid bits, the task count,
// the tick counter and the outstanding fire live in flip-flops. Every accepted
// item returns exactly one result item. An insert, a complete that retires
// its task, a tick while a fire is still outstanding and the unused command
// go from the idle state to the result state and back to idle. A complete
// that reschedules also passes the write-back state (one memory read, one
// write back). A tick that may fire walks the table through the single memory
// read port, one slot per cycle, then the last and fire states. Times wrap at
// TIME_BITS bits and are ordered by modular difference; of the due tasks the
// earliest fires, the lowest slot on a tie. A result waits in the output
// register until taken while the next item is already accepted and worked on.
// One item is in work at a time, so a memory write always lands before the
// next read and no forwarding is needed. The memory needs no clearing after
// reset: an entry is used only while its valid bit is set.
module periodic_task_timer_scheduler #(
    parameter int TASK_SLOTS = tsch_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = tsch_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS   = tsch_pkg::TAG_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tsch_in_if.sink    task_cmd,
    tsch_out_if.source task_result
);
    localparam int SLOT_BITS   = $clog2(TASK_SLOTS);
    localparam int COUNT_BITS  = $clog2(TASK_SLOTS + 1);
    localparam int PERIOD_BITS = tsch_pkg::PERIOD_BITS;
    localparam int ENTRY_BITS  = TIME_BITS + PERIOD_BITS + TAG_BITS;
    localparam int SUM_BITS    = TIME_BITS + PERIOD_BITS;
    // Entry layout: {due, period, tag}
    localparam int PER_LSB = TAG_BITS;
    localparam int DUE_LSB = TAG_BITS + PERIOD_BITS;

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;  // take an item
    localparam logic [2:0] S_SCAN    = 3'd1;  // issue one slot read per cycle
    localparam logic [2:0] S_LAST    = 3'd2;  // judge the last slot read
    localparam logic [2:0] S_FIRE    = 3'd3;  // commit the chosen task
    localparam logic [2:0] S_RESCHED = 3'd4;  // write back the new due time
    localparam logic [2:0] S_RESULT  = 3'd5;  // hand the result to the output

    logic [2:0]            state_reg, state_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  pending_reg, pending_next;
    logic [SLOT_BITS-1:0]  pending_slot_reg, pending_slot_next;
    logic [TIME_BITS-1:0]  fire_time_reg, fire_time_next;
    logic [SLOT_BITS-1:0]  scan_idx_reg, scan_idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [SLOT_BITS-1:0]  rd_idx_reg, rd_idx_next;
    logic                  out_valid_reg, out_valid_next;

    // Result payload, staged and then presented
    logic [tsch_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic                             res_fire_reg, res_fire_next;
    logic [SLOT_BITS-1:0]             res_slot_reg, res_slot_next;
    logic [TAG_BITS-1:0]              res_tag_reg, res_tag_next;
    logic [tsch_pkg::STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic                             out_fire_reg, out_fire_next;
    logic [SLOT_BITS-1:0]             out_slot_reg, out_slot_next;
    logic [TAG_BITS-1:0]              out_tag_reg, out_tag_next;
    logic [COUNT_BITS-1:0]            out_count_reg, out_count_next;

    logic                  accept;
    logic                  out_free;
    logic                  free_any;
    logic [SLOT_BITS-1:0]  free_idx;
    logic [SUM_BITS-1:0]   ins_sum;
    logic [SUM_BITS-1:0]   resched_sum;

    logic                  mem_wr_en;
    logic [SLOT_BITS-1:0]  mem_wr_addr;
    logic [ENTRY_BITS-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [SLOT_BITS-1:0]  mem_rd_addr;
    logic [ENTRY_BITS-1:0] mem_rd_data;

    tsch_pkg::pick_ctl_t   pick_ctl;
    logic                  pick_have;
    logic [SLOT_BITS-1:0]  pick_idx;
    logic [TAG_BITS-1:0]   pick_tag;

    tsch_mem #(
        .DEPTH (TASK_SLOTS),
        .WIDTH (ENTRY_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tsch_pick #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pick_ctl),
        .now      (now_reg),
        .cand_idx (rd_idx_reg),
        .cand_due (mem_rd_data[DUE_LSB +: TIME_BITS]),
        .cand_tag (mem_rd_data[TAG_BITS-1:0]),
        .have     (pick_have),
        .best_idx (pick_idx),
        .best_tag (pick_tag)
    );

    // Handshakes: take an item only when idle; the output register frees on take
    assign task_cmd.ready = (state_reg == S_IDLE);
    assign accept         = task_cmd.valid && task_cmd.ready;
    assign out_free       = !out_valid_reg || task_result.ready;

    // Lowest free slot
    always_comb
    begin
        free_any = ~&valid_reg;
        free_idx = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    // Due sums wrap at TIME_BITS: add at full width, keep the low bits
    assign ins_sum = {{PERIOD_BITS{1'b0}}, now_reg}
                   + {{TIME_BITS{1'b0}}, task_cmd.interval_ticks};
    assign resched_sum = {{PERIOD_BITS{1'b0}}, fire_time_reg}
                       + {{TIME_BITS{1'b0}}, mem_rd_data[PER_LSB +: PERIOD_BITS]};

    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        valid_next        = valid_reg;
        count_next        = count_reg;
        pending_next      = pending_reg;
        pending_slot_next = pending_slot_reg;
        fire_time_next    = fire_time_reg;
        scan_idx_next     = scan_idx_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        res_status_next   = res_status_reg;
        res_fire_next     = res_fire_reg;
        res_slot_next     = res_slot_reg;
        res_tag_next      = res_tag_reg;
        out_valid_next    = out_valid_reg && !task_result.ready;
        out_status_next   = out_status_reg;
        out_fire_next     = out_fire_reg;
        out_slot_next     = out_slot_reg;
        out_tag_next      = out_tag_reg;
        out_count_next    = out_count_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = pending_slot_reg;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = pending_slot_reg;

        // Judge every slot read that comes back, if its task exists
        pick_ctl.clear  = 1'b0;
        pick_ctl.sample = rd_vld_reg && valid_reg[rd_idx_reg];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = tsch_pkg::STATUS_OK;
                    res_fire_next   = 1'b0;
                    res_slot_next   = '0;
                    res_tag_next    = '0;
                    state_next      = S_RESULT;
                    case (task_cmd.command)
                        tsch_pkg::CMD_INSERT:
                        begin
                            if (free_any)
                            begin
                                mem_wr_en            = 1'b1;
                                mem_wr_addr          = free_idx;
                                mem_wr_data          = {ins_sum[TIME_BITS-1:0],
                                                        task_cmd.interval_ticks,
                                                        task_cmd.task_tag};
                                valid_next[free_idx] = 1'b1;
                                count_next           = count_reg + COUNT_BITS'(1);
                                res_slot_next        = free_idx;
                            end
                            else
                            begin
                                res_status_next = tsch_pkg::STATUS_FULL;
                            end
                        end
                        tsch_pkg::CMD_TICK:
                        begin
                            now_next = now_reg + TIME_BITS'(1);
                            if (!pending_reg)
                            begin
                                scan_idx_next  = '0;
                                pick_ctl.clear = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        tsch_pkg::CMD_COMPLETE:
                        begin
                            if (!pending_reg)
                            begin
                                res_status_next = tsch_pkg::STATUS_NO_FIRE;
                            end
                            else
                            begin
                                res_slot_next = pending_slot_reg;
                                if (task_cmd.task_done)
                                begin
                                    valid_next[pending_slot_reg] = 1'b0;
                                    count_next   = count_reg - COUNT_BITS'(1);
                                    pending_next = 1'b0;
                                end
                                else
                                begin
                                    // Fetch period and tag for the write back
                                    mem_rd_en  = 1'b1;
                                    state_next = S_RESCHED;
                                end
                            end
                        end
                        default:
                        begin
                            // Unused command: plain ok result
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = scan_idx_reg;
                rd_vld_next = 1'b1;
                rd_idx_next = scan_idx_reg;
                if (scan_idx_reg == SLOT_BITS'(TASK_SLOTS - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + SLOT_BITS'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_FIRE;
            end
            S_FIRE:
            begin
                if (pick_have)
                begin
                    pending_next      = 1'b1;
                    pending_slot_next = pick_idx;
                    fire_time_next    = now_reg;
                    res_fire_next     = 1'b1;
                    res_slot_next     = pick_idx;
                    res_tag_next      = pick_tag;
                end
                state_next = S_RESULT;
            end
            S_RESCHED:
            begin
                // Keep period and tag, advance due from the fire time
                mem_wr_en    = 1'b1;
                mem_wr_data  = {resched_sum[TIME_BITS-1:0],
                                mem_rd_data[PERIOD_BITS+TAG_BITS-1:0]};
                pending_next = 1'b0;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_fire_next   = res_fire_reg;
                    out_slot_next   = res_slot_reg;
                    out_tag_next    = res_tag_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            now_reg          <= '0;
            valid_reg        <= '0;
            count_reg        <= '0;
            pending_reg      <= 1'b0;
            pending_slot_reg <= '0;
            fire_time_reg    <= '0;
            scan_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            now_reg          <= now_next;
            valid_reg        <= valid_next;
            count_reg        <= count_next;
            pending_reg      <= pending_next;
            pending_slot_reg <= pending_slot_next;
            fire_time_reg    <= fire_time_next;
            scan_idx_reg     <= scan_idx_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_fire_reg   <= res_fire_next;
        res_slot_reg   <= res_slot_next;
        res_tag_reg    <= res_tag_next;
        out_status_reg <= out_status_next;
        out_fire_reg   <= out_fire_next;
        out_slot_reg   <= out_slot_next;
        out_tag_reg    <= out_tag_next;
        out_count_reg  <= out_count_next;
    end

    assign task_result.valid      = out_valid_reg;
    assign task_result.status     = out_status_reg;
    assign task_result.fire_valid = out_fire_reg;
    assign task_result.fire_slot  = out_slot_reg;
    assign task_result.fire_tag   = out_tag_reg;
    assign task_result.task_count = out_count_reg;

    // The task count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_BITS'($countones(valid_reg)))
        else $error("task count out of step with valid bits");

    // An outstanding fire always refers to a live task
    a_pending_live: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> valid_reg[pending_slot_reg])
        else $error("pending fire on an empty slot");

    // A scan starts only with no fire outstanding
    a_scan_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !pending_reg)
        else $error("slot scan while a fire is pending");

    // A tick advances the counter by one
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && task_cmd.command == tsch_pkg::CMD_TICK)
        |=> now_reg == $past(now_reg) + TIME_BITS'(1))
        else $error("tick did not advance the counter");
endmodule
